// ===== sv/fram_pkg.sv =====
// ----------------------------------------------------------------------------
// fram_pkg: shared types and constants for the framed byte ring FIFO
// Holds the command and status codes, the field widths of the stream items
// and the job record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package fram_pkg;

	// Default sizes of the ring and of one burst read.
	localparam int DEPTH_DEF    = 4096;
	localparam int MAX_READ_DEF = 64;

	// Fixed field widths of the stream items.
	localparam int CMD_W  = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 12;
	localparam int CNT_W  = 7;
	localparam int STAT_W = 2;

	// Widest ring supported sets the width of the job fields.
	localparam int ADDR_MAX_W = 16;
	localparam int FREE_MAX_W = 17;

	// Number of jobs that may wait between the front and the back part.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK          = 2'd0,
		ST_NOT_STARTED = 2'd1,
		ST_REJECT      = 2'd2,
		ST_EMPTY       = 2'd3
	} status_e_t;

	// One unit of work for the back part: a store, a burst read or a plain reply.
	typedef struct packed {
		logic                  is_read;
		logic                  store;
		status_e_t             status;
		logic [ADDR_MAX_W-1:0] addr;
		logic [BYTE_W-1:0]     data;
		logic [CNT_W-1:0]      count;
		logic [FREE_MAX_W-1:0] free;
	} job_t;

endpackage

`default_nettype wire

// ===== sv/fram_front.sv =====
// ----------------------------------------------------------------------------
// fram_front: command front end of the framed byte ring FIFO
// Keeps the pointers, fill count, running flag and frame state, decides the
// outcome of every input item and hands one job per item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fram_front import fram_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int MAX_READ = MAX_READ_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              frame_first,
	input  logic [LEN_W-1:0]  frame_len,
	input  logic [CNT_W-1:0]  max_len,
	output logic              job_valid,
	input  logic              job_ready,
	output job_t              job
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = ((AW > LEN_W) ? AW : LEN_W) + 1;
	localparam int NW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [AW-1:0]         LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [LW-1:0]         FIT_LIMIT = LW'(DEPTH - 1);
	localparam logic [NW-1:0]         DEPTH_N   = NW'(DEPTH);
	localparam logic [CNT_W-1:0]      READ_CAP  = CNT_W'(MAX_READ);
	localparam logic [FREE_MAX_W-1:0] DEPTH_F   = FREE_MAX_W'(DEPTH);

	logic [AW-1:0]    wp_q, rp_q, used_q;
	logic [AW-1:0]    wp_d, rp_d, used_d;
	logic             running_q, running_d;
	logic             admitted_q, admitted_d;
	logic [LEN_W-1:0] left_q, left_d;

	logic [LEN_W-1:0] flen_eff;
	logic             frame_fits;
	logic             room;
	logic [AW-1:0]    wp_inc;
	logic [CNT_W-1:0] mlen;
	logic [NW-1:0]    n_rd;
	logic [NW-1:0]    rp_sum;
	logic [NW-1:0]    rp_wrap;
	logic             do_store;

	// Every item goes straight into the queue.
	assign in_ready  = job_ready;
	assign job_valid = in_valid;

	// Frame admission: a zero length counts as one byte.
	assign flen_eff   = (frame_len == '0) ? LEN_W'(1) : frame_len;
	assign frame_fits = (LW'(used_q) + LW'(flen_eff)) <= FIT_LIMIT;
	assign room       = used_q < LAST_SLOT;
	assign wp_inc     = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;

	// Burst length: clamp the request, then limit it to the stored count.
	always_comb begin
		if (max_len == '0) begin
			mlen = CNT_W'(1);
		end else if (max_len > READ_CAP) begin
			mlen = READ_CAP;
		end else begin
			mlen = max_len;
		end
	end

	assign n_rd    = (NW'(used_q) < NW'(mlen)) ? NW'(used_q) : NW'(mlen);
	assign rp_sum  = NW'(rp_q) + n_rd;
	assign rp_wrap = (rp_sum >= DEPTH_N) ? rp_sum - DEPTH_N : rp_sum;

	// Decide the outcome of the item and the next state.
	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		used_d     = used_q;
		running_d  = running_q;
		admitted_d = admitted_q;
		left_d     = left_q;
		do_store   = 1'b0;
		job        = '0;
		job.status = ST_OK;

		case (cmd_e_t'(cmd))
			CMD_START: begin
				wp_d       = '0;
				rp_d       = '0;
				used_d     = '0;
				running_d  = 1'b1;
				admitted_d = 1'b0;
				left_d     = '0;
			end
			CMD_STOP: begin
				running_d = 1'b0;
			end
			CMD_WRITE: begin
				if (!running_q) begin
					job.status = ST_NOT_STARTED;
				end else if (frame_first) begin
					// A first byte always opens a new frame.
					left_d = flen_eff - 1'b1;
					if (frame_fits) begin
						admitted_d = 1'b1;
						do_store   = 1'b1;
					end else begin
						admitted_d = 1'b0;
						job.status = ST_REJECT;
					end
				end else if (left_q == '0) begin
					// Stray byte with no open frame.
					job.status = ST_REJECT;
				end else begin
					left_d = left_q - 1'b1;
					if (admitted_q && room) begin
						do_store = 1'b1;
					end else begin
						job.status = ST_REJECT;
					end
				end
				if (do_store) begin
					job.store = 1'b1;
					job.addr  = ADDR_MAX_W'(wp_q);
					job.data  = data_byte;
					wp_d      = wp_inc;
					used_d    = used_q + 1'b1;
				end
			end
			CMD_READ: begin
				if (!running_q) begin
					job.status = ST_NOT_STARTED;
				end else if (used_q == '0) begin
					job.status = ST_EMPTY;
				end else begin
					job.is_read = 1'b1;
					job.addr    = ADDR_MAX_W'(rp_q);
					job.count   = CNT_W'(n_rd);
					rp_d        = AW'(rp_wrap);
					used_d      = used_q - AW'(n_rd);
				end
			end
			default: begin
			end
		endcase

		job.free = DEPTH_F - FREE_MAX_W'(used_d);
	end

	// Control state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			used_q     <= '0;
			running_q  <= 1'b0;
			admitted_q <= 1'b0;
			left_q     <= '0;
		end else if (in_valid && in_ready) begin
			wp_q       <= wp_d;
			rp_q       <= rp_d;
			used_q     <= used_d;
			running_q  <= running_d;
			admitted_q <= admitted_d;
			left_q     <= left_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fram_queue.sv =====
// ----------------------------------------------------------------------------
// fram_queue: job queue between the front and the back part
// A small first-in first-out store of job records so that the front keeps
// accepting items while the back part streams out a burst read.
// ----------------------------------------------------------------------------
`default_nettype none

module fram_queue import fram_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output job_t out_job
);

	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam logic [QAW-1:0] LAST_ENTRY = QAW'(QDEPTH - 1);
	localparam logic [QCW-1:0] FULL_COUNT = QCW'(QDEPTH);

	job_t           slots_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push, pop;

	assign in_ready  = count_q != FULL_COUNT;
	assign out_valid = count_q != '0;
	assign out_job   = slots_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_ENTRY) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_ENTRY) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/fram_back.sv =====
// ----------------------------------------------------------------------------
// fram_back: storage and result back end of the framed byte ring FIFO
// Owns the ring memory, carries out stores and burst reads one memory access
// per cycle while results drain, and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fram_back import fram_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int FREE_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	output logic              res_valid,
	input  logic              res_ready,
	output status_e_t         status,
	output logic [BYTE_W-1:0] read_byte,
	output logic [CNT_W-1:0]  read_count,
	output logic              last,
	output logic [FREE_W-1:0] free_space
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	logic [BYTE_W-1:0]     ring_q [DEPTH];
	logic [CNT_W-1:0]      idx_q;
	logic                  valid_s1;
	status_e_t             status_s1;
	logic [BYTE_W-1:0]     rd_s1;
	logic [CNT_W-1:0]      count_s1;
	logic                  last_s1;
	logic [FREE_MAX_W-1:0] free_s1;
	logic                  is_read_s1;

	logic          load_s1, take, last_byte;
	logic [SW-1:0] addr_sum, addr_wrap;
	logic [AW-1:0] rd_addr, wr_addr;

	// The output register takes a new result when empty or being emptied.
	assign load_s1   = !valid_s1 || res_ready;
	assign take      = job_valid && load_s1;
	assign last_byte = (idx_q + CNT_W'(1)) == job.count;
	assign job_ready = take && (!job.is_read || last_byte);

	// Burst address: start of the burst plus the byte index, wrapped.
	assign addr_sum  = SW'(job.addr[AW-1:0]) + SW'(idx_q);
	assign addr_wrap = (addr_sum >= DEPTH_S) ? addr_sum - DEPTH_S : addr_sum;
	assign rd_addr   = AW'(addr_wrap);
	assign wr_addr   = job.addr[AW-1:0];

	// Ring memory: one store or one read per cycle when a job is taken, read data registered.
	always_ff @(posedge clk) begin
		if (take && job.store) begin
			ring_q[wr_addr] <= job.data;
		end
		if (take && job.is_read) begin
			rd_s1 <= ring_q[rd_addr];
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			status_s1  <= job.status;
			count_s1   <= job.count;
			last_s1    <= !job.is_read || last_byte;
			free_s1    <= job.free;
			is_read_s1 <= job.is_read;
		end
	end

	// Output valid flag and byte index within a burst.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= job_valid;
			end
			if (take) begin
				idx_q <= (job.is_read && !last_byte) ? idx_q + 1'b1 : '0;
			end
		end
	end

	assign res_valid  = valid_s1;
	assign status     = status_s1;
	assign read_byte  = is_read_s1 ? rd_s1 : '0;
	assign read_count = count_s1;
	assign last       = last_s1;
	assign free_space = FREE_W'(free_s1);

endmodule

`default_nettype wire

// ===== sv/byte_ring_fifo_frame_admit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_frame_admit: byte ring FIFO with whole-frame admission
// Top level: unpacks the input stream, joins the front part, the job queue
// and the back part, and packs the result stream.
// ----------------------------------------------------------------------------
// A byte ring FIFO of DEPTH bytes, one slot of which always stays unused. A
// start item clears the ring and sets it running, a stop item halts it. Write
// items carry one byte each; the first byte of a frame carries the frame
// length and the whole frame is stored only if it fits. A read item returns up
// to MAX_READ stored bytes as a burst of results, the last one marked by
// m_tlast, and every result carries the free space. Start, stop and write items
// are taken one per cycle while the job queue has room. A read of n bytes keeps
// the back part busy until its last byte, as the single-port ring memory gives
// one byte per cycle while the results are taken; the read job holds its queue
// entry until its last byte, so meanwhile up to three further items are queued.
// The ring needs no clearing after reset, so the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_frame_admit import fram_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int MAX_READ = MAX_READ_DEF,
	localparam int FREE_W  = $clog2(DEPTH + 1),
	localparam int M_DATA_W = ((BYTE_W + CNT_W + FREE_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,  // data_byte, frame_len, max_len
	input  logic [2:0]          s_tuser,  // cmd, frame_first
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // read_byte, read_count, free_space
	output logic [STAT_W-1:0]   m_tuser,  // status
	output logic                m_tlast
);

	job_t              fr_job, bk_job;
	logic              fr_valid, fr_ready, bk_valid, bk_ready;
	status_e_t         out_status;
	logic [BYTE_W-1:0] out_byte;
	logic [CNT_W-1:0]  out_count;
	logic [FREE_W-1:0] out_free;

	// Front part: decides every item.
	fram_front #(
		.DEPTH    (DEPTH),
		.MAX_READ (MAX_READ)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.cmd         (s_tuser[1:0]),
		.data_byte   (s_tdata[7:0]),
		.frame_first (s_tuser[2]),
		.frame_len   (s_tdata[19:8]),
		.max_len     (s_tdata[26:20]),
		.job_valid   (fr_valid),
		.job_ready   (fr_ready),
		.job         (fr_job)
	);

	// Job queue between the two parts.
	fram_queue #(
		.QDEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_job    (fr_job),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_job   (bk_job)
	);

	// Back part: ring memory and results.
	fram_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (bk_valid),
		.job_ready  (bk_ready),
		.job        (bk_job),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.status     (out_status),
		.read_byte  (out_byte),
		.read_count (out_count),
		.last       (m_tlast),
		.free_space (out_free)
	);

	// Pack the result stream.
	assign m_tdata = M_DATA_W'({out_free, out_count, out_byte});
	assign m_tuser = out_status;

	// A burst read is only ever reported with an ok status.
	a_count_ok : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_count != '0 |-> out_status == ST_OK)
		else $error("read burst with a failing status");

	// Every result that is not part of a burst closes its item.
	a_single_last : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_count == '0 |-> m_tlast && out_byte == '0)
		else $error("single result without last or with a byte");

	// The free space never exceeds the ring size.
	a_free_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_free <= FREE_W'(DEPTH))
		else $error("free space beyond ring size");

	// Within a burst the count and free space stay the same from byte to byte.
	a_burst_steady : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid
		|-> out_count == $past(out_count) && out_free == $past(out_free))
		else $error("burst fields changed before its last byte");

endmodule

`default_nettype wire
